// ===== rtl/core/bttpc_pkg.sv =====
// Shared types and constants for the button tap and press classifier.
package bttpc_pkg;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam int TIME_W = 32;
    localparam int TAP_W = 8;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_DEBOUNCE_TIME      = 4'd0;
    localparam t_cfg_idx CFG_DOUBLE_TAP_GAP     = 4'd1;
    localparam t_cfg_idx CFG_LONG_PRESS_TIME    = 4'd2;
    localparam t_cfg_idx CFG_FACTORY_RESET_TIME = 4'd3;

    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_TIME_RST      = 16'd50;
    localparam logic [CFG_DATA_W-1:0] DOUBLE_TAP_GAP_RST     = 16'd400;
    localparam logic [CFG_DATA_W-1:0] LONG_PRESS_TIME_RST    = 16'd3000;
    localparam logic [CFG_DATA_W-1:0] FACTORY_RESET_TIME_RST = 16'd10000;

    localparam logic [TAP_W-1:0] TAP_MAX = 8'd255;

    typedef struct packed {
        logic              button_down;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [TAP_W-1:0] taps_done;
        logic             long_press_event;
        logic             factory_reset_event;
    } t_out_item;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] debounce_time;
        logic [CFG_DATA_W-1:0] double_tap_gap;
        logic [CFG_DATA_W-1:0] long_press_time;
        logic [CFG_DATA_W-1:0] factory_reset_time;
    } t_cfg;

endpackage

// ===== rtl/core/bttpc_cfg_regs.sv =====
// Configuration register file for the button tap and press classifier.
module bttpc_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  bttpc_pkg::t_cfg_idx                 i_wr_idx,
    input  logic [bttpc_pkg::CFG_DATA_W-1:0]    i_wr_data,
    output bttpc_pkg::t_cfg                     o_cfg
);

    bttpc_pkg::t_cfg r_cfg;
    bttpc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_idx)
                bttpc_pkg::CFG_DEBOUNCE_TIME:      n_cfg.debounce_time      = i_wr_data;
                bttpc_pkg::CFG_DOUBLE_TAP_GAP:     n_cfg.double_tap_gap     = i_wr_data;
                bttpc_pkg::CFG_LONG_PRESS_TIME:    n_cfg.long_press_time    = i_wr_data;
                bttpc_pkg::CFG_FACTORY_RESET_TIME: n_cfg.factory_reset_time = i_wr_data;
                default:                           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time      <= bttpc_pkg::DEBOUNCE_TIME_RST;
            r_cfg.double_tap_gap     <= bttpc_pkg::DOUBLE_TAP_GAP_RST;
            r_cfg.long_press_time    <= bttpc_pkg::LONG_PRESS_TIME_RST;
            r_cfg.factory_reset_time <= bttpc_pkg::FACTORY_RESET_TIME_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/bttpc_tracker.sv =====
// Press and tap state tracking with one-sample result generation.
module bttpc_tracker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  bttpc_pkg::t_in_item  i_item,
    input  bttpc_pkg::t_cfg      i_cfg,
    output bttpc_pkg::t_out_item o_result
);

    logic                              r_pressed;
    logic [bttpc_pkg::TIME_W-1:0]      r_press_start;
    logic [bttpc_pkg::TIME_W-1:0]      r_last_tap;
    logic [bttpc_pkg::TAP_W-1:0]       r_tap_cnt;
    logic                              r_long_done;
    logic                              r_vlong_done;

    logic                              n_pressed;
    logic [bttpc_pkg::TIME_W-1:0]      n_press_start;
    logic [bttpc_pkg::TIME_W-1:0]      n_last_tap;
    logic [bttpc_pkg::TAP_W-1:0]       n_tap_cnt;
    logic                              n_long_done;
    logic                              n_vlong_done;

    logic                              new_press;
    logic                              release_ev;
    logic                              ld1;
    logic                              vld1;
    logic [bttpc_pkg::TIME_W-1:0]      held;
    logic [bttpc_pkg::TIME_W-1:0]      gap;
    logic                              gap_lt;
    logic                              gap1_lt;
    logic                              is_tap;
    logic [bttpc_pkg::TAP_W-1:0]       tc1;
    logic                              fact_ev;
    logic                              long_ev;
    logic                              report;

    always_comb begin
        new_press  = i_item.button_down && !r_pressed;
        release_ev = !i_item.button_down && r_pressed;
        ld1        = new_press ? 1'b0 : r_long_done;
        vld1       = new_press ? 1'b0 : r_vlong_done;
        held       = new_press ? '0 : (i_item.now_ms - r_press_start);
        gap        = i_item.now_ms - r_last_tap;
        gap_lt     = gap < {{(bttpc_pkg::TIME_W-bttpc_pkg::CFG_DATA_W){1'b0}},
                            i_cfg.double_tap_gap};

        is_tap = release_ev && !ld1 && !vld1
              && (held >= {{(bttpc_pkg::TIME_W-bttpc_pkg::CFG_DATA_W){1'b0}},
                           i_cfg.debounce_time});

        tc1 = r_tap_cnt;
        if (is_tap) begin
            if (gap_lt && (r_tap_cnt != '0)) begin
                if (r_tap_cnt != bttpc_pkg::TAP_MAX) begin
                    tc1 = r_tap_cnt + 1'b1;
                end
            end else begin
                tc1 = {{(bttpc_pkg::TAP_W-1){1'b0}}, 1'b1};
            end
        end

        fact_ev = i_item.button_down && !vld1
               && (held >= {{(bttpc_pkg::TIME_W-bttpc_pkg::CFG_DATA_W){1'b0}},
                            i_cfg.factory_reset_time});
        long_ev = i_item.button_down && !ld1 && !vld1 && !fact_ev
               && (held >= {{(bttpc_pkg::TIME_W-bttpc_pkg::CFG_DATA_W){1'b0}},
                            i_cfg.long_press_time});

        gap1_lt = is_tap ? (i_cfg.double_tap_gap != '0) : gap_lt;
        report  = !i_item.button_down && (tc1 != '0)
               && !((tc1 == {{(bttpc_pkg::TAP_W-1){1'b0}}, 1'b1}) && gap1_lt);

        n_pressed     = i_item.button_down;
        n_press_start = new_press ? i_item.now_ms : r_press_start;
        n_last_tap    = is_tap ? i_item.now_ms : r_last_tap;
        n_long_done   = ld1 || long_ev;
        n_vlong_done  = vld1 || fact_ev;
        n_tap_cnt     = (fact_ev || long_ev || report) ? '0 : tc1;

        o_result.taps_done           = report ? tc1 : '0;
        o_result.long_press_event    = long_ev;
        o_result.factory_reset_event = fact_ev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed     <= 1'b0;
            r_press_start <= '0;
            r_last_tap    <= '0;
            r_tap_cnt     <= '0;
            r_long_done   <= 1'b0;
            r_vlong_done  <= 1'b0;
        end else if (i_fire) begin
            r_pressed     <= n_pressed;
            r_press_start <= n_press_start;
            r_last_tap    <= n_last_tap;
            r_tap_cnt     <= n_tap_cnt;
            r_long_done   <= n_long_done;
            r_vlong_done  <= n_vlong_done;
        end
    end

endmodule

// ===== rtl/core/button_tap_press_classifier_core.sv =====
// Top level of the button tap and press classifier: request registers and result register.
//
// One request (button level plus millisecond timestamp) is taken every clock cycle
// unless the result register is stalled, and gives exactly one result: the request
// is held in the request register, the tracker update works on it there, and its
// result is captured in the result register when the update fires.
// The tracker's compare/subtract logic updates all press and tap state at once, so a
// sustained throughput of one request per cycle holds as long as results are taken.
// Reported taps come out when the button is released; unless the double-tap gap is
// zero, a lone tap waits until a later request shows the double-tap gap has passed.
// Configuration writes are always accepted; indexes outside 0..3 are ignored.
module button_tap_press_classifier_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  bttpc_pkg::t_in_item              i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output bttpc_pkg::t_out_item             o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  bttpc_pkg::t_cfg_idx              i_cfg_index,
    input  logic [bttpc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic                 r_in_valid;
    bttpc_pkg::t_in_item  r_in_item;
    logic                 r_out_valid;
    bttpc_pkg::t_out_item r_out_item;

    logic                 out_free;
    logic                 fire;
    bttpc_pkg::t_cfg      cfg;
    bttpc_pkg::t_out_item result;

    assign out_free    = !r_out_valid || i_out_ready;
    assign fire        = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || out_free;
    assign o_cfg_ready = 1'b1;

    bttpc_cfg_regs u_cfg_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_valid),
        .i_wr_idx  (i_cfg_index),
        .i_wr_data (i_cfg_data),
        .o_cfg     (cfg)
    );

    bttpc_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
        if (fire) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    a_fire_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("result register not filled after update");

    a_stall_holds_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_in_item)))
        else $error("pending request lost during stall");

    a_single_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_item.long_press_event && r_out_item.factory_reset_event))
        else $error("long and factory events in one result");

    a_no_taps_with_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_item.long_press_event || r_out_item.factory_reset_event))
        |-> (r_out_item.taps_done == '0))
        else $error("taps reported while button held");

endmodule

// ===== test/testbench.sv =====
// Testbench for the button tap and press classifier: directed and random gestures checked against a local predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bttpc_pkg::*;

    localparam int ITEM_TARGET  = 1350;
    localparam int QUIET_ITEMS  = 150;
    localparam int PHASE_ITEMS  = 150;
    localparam int PARK_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    t_cfg_idx              cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  trk_pressed;
    logic [TIME_W-1:0]     trk_press_start;
    logic [TIME_W-1:0]     trk_last_tap;
    logic [TAP_W-1:0]      trk_taps;
    logic                  trk_long_fired;
    logic                  trk_factory_fired;
    logic [CFG_DATA_W-1:0] cfg_debounce;
    logic [CFG_DATA_W-1:0] cfg_tap_gap;
    logic [CFG_DATA_W-1:0] cfg_long;
    logic [CFG_DATA_W-1:0] cfg_factory;

    t_out_item             pending_reports[$];
    logic [TIME_W-1:0]     cur_ms = '0;
    int                    items_sent = 0;
    int                    mismatches = 0;
    int                    quiet_cycles = 0;
    logic                  sender_gaps = 1'b1;
    logic                  receiver_stalls = 1'b1;
    logic                  park_req = 1'b0;

    button_tap_press_classifier_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void reset_tracker();
        trk_pressed       = 1'b0;
        trk_press_start   = '0;
        trk_last_tap      = '0;
        trk_taps          = '0;
        trk_long_fired    = 1'b0;
        trk_factory_fired = 1'b0;
        cfg_debounce      = DEBOUNCE_TIME_RST;
        cfg_tap_gap       = DOUBLE_TAP_GAP_RST;
        cfg_long          = LONG_PRESS_TIME_RST;
        cfg_factory       = FACTORY_RESET_TIME_RST;
    endfunction

    function automatic t_out_item classify_sample(t_in_item req);
        logic [TIME_W-1:0] held;
        logic [TIME_W-1:0] since_tap;
        t_out_item         res;
        res = '0;
        if (req.button_down && !trk_pressed) begin
            trk_pressed       = 1'b1;
            trk_press_start   = req.now_ms;
            trk_long_fired    = 1'b0;
            trk_factory_fired = 1'b0;
        end
        if (!req.button_down && trk_pressed) begin
            trk_pressed = 1'b0;
            held        = req.now_ms - trk_press_start;
            since_tap   = req.now_ms - trk_last_tap;
            if (!trk_long_fired && !trk_factory_fired && held >= TIME_W'(cfg_debounce)) begin
                if (since_tap < TIME_W'(cfg_tap_gap) && trk_taps != '0) begin
                    if (trk_taps < TAP_MAX) trk_taps = trk_taps + 1'b1;
                end else begin
                    trk_taps = 8'd1;
                end
                trk_last_tap = req.now_ms;
            end
        end
        if (trk_pressed) begin
            held = req.now_ms - trk_press_start;
            if (!trk_factory_fired && held >= TIME_W'(cfg_factory)) begin
                trk_factory_fired       = 1'b1;
                trk_taps                = '0;
                res.factory_reset_event = 1'b1;
            end
            if (!trk_long_fired && !trk_factory_fired && held >= TIME_W'(cfg_long)) begin
                trk_long_fired       = 1'b1;
                trk_taps             = '0;
                res.long_press_event = 1'b1;
            end
        end
        since_tap = req.now_ms - trk_last_tap;
        if (!trk_pressed && trk_taps != '0) begin
            if (!(trk_taps == 8'd1 && since_tap < TIME_W'(cfg_tap_gap))) begin
                res.taps_done = trk_taps;
                trk_taps      = '0;
            end
        end
        return res;
    endfunction

    function automatic logic [TIME_W-1:0] near_ms(logic [CFG_DATA_W-1:0] th);
        logic [TIME_W-1:0] wide;
        wide = TIME_W'(th);
        case ($urandom_range(0, 5))
            0: return (wide == '0) ? wide : wide - 1;
            1: return wide;
            2: return wide + 1;
            3: return $urandom_range(0, wide);
            4: return wide + $urandom_range(1, 200);
            default: return $urandom_range(0, 30);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_setting();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(0, 600));
        endcase
    endfunction

    task automatic send_sample(logic down, logic [TIME_W-1:0] stamp);
        t_in_item req;
        req.button_down = down;
        req.now_ms      = stamp;
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        pending_reports.push_back(classify_sample(req));
        items_sent++;
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_DEBOUNCE_TIME:      cfg_debounce = value;
            CFG_DOUBLE_TAP_GAP:     cfg_tap_gap  = value;
            CFG_LONG_PRESS_TIME:    cfg_long     = value;
            CFG_FACTORY_RESET_TIME: cfg_factory  = value;
            default: ;
        endcase
    endtask

    task automatic program_registers(logic [CFG_DATA_W-1:0] deb, logic [CFG_DATA_W-1:0] gap,
                                     logic [CFG_DATA_W-1:0] hold_long,
                                     logic [CFG_DATA_W-1:0] hold_factory);
        wait_results_drained();
        write_register(CFG_DEBOUNCE_TIME, deb);
        write_register(CFG_DOUBLE_TAP_GAP, gap);
        write_register(CFG_LONG_PRESS_TIME, hold_long);
        write_register(CFG_FACTORY_RESET_TIME, hold_factory);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_gesture();
        logic [TIME_W-1:0] press_t;
        logic [TIME_W-1:0] release_t;
        logic [TIME_W-1:0] target;
        int                holds;
        int                pauses;
        if ($urandom_range(0, 9) == 0) begin
            cur_ms = $urandom;
            send_sample(1'($urandom_range(0, 1)), cur_ms);
            return;
        end
        holds   = $urandom_range(0, 4);
        pauses  = $urandom_range(0, 3);
        press_t = cur_ms;
        send_sample(1'b1, cur_ms);
        repeat (holds) begin
            target = ($urandom_range(0, 1) == 0) ? near_ms(cfg_long) : near_ms(cfg_factory);
            cur_ms = (target > cur_ms - press_t) ? press_t + target
                                                 : cur_ms + $urandom_range(0, 50);
            send_sample(1'b1, cur_ms);
        end
        target = near_ms(cfg_debounce);
        cur_ms = (target > cur_ms - press_t) ? press_t + target : cur_ms + $urandom_range(0, 50);
        send_sample(1'b0, cur_ms);
        release_t = cur_ms;
        repeat (pauses) begin
            target = near_ms(cfg_tap_gap);
            cur_ms = (target > cur_ms - release_t) ? release_t + target
                                                   : cur_ms + $urandom_range(0, 50);
            send_sample(1'b0, cur_ms);
        end
    endtask

    task automatic test_default_gestures();
        send_sample(1'b1, 32'd1000);
        send_sample(1'b0, 32'd1010);
        send_sample(1'b1, 32'd2000);
        send_sample(1'b0, 32'd2100);
        send_sample(1'b1, 32'd2200);
        send_sample(1'b0, 32'd2300);
        send_sample(1'b1, 32'd3000);
        send_sample(1'b0, 32'd3100);
        send_sample(1'b0, 32'd3600);
        send_sample(1'b1, 32'd5000);
        send_sample(1'b1, 32'd8000);
        send_sample(1'b1, 32'd15000);
        send_sample(1'b0, 32'd15100);
        send_sample(1'b1, 32'd20000);
        send_sample(1'b1, 32'd30000);
        send_sample(1'b1, 32'd30001);
        send_sample(1'b0, 32'd30002);
        send_sample(1'b1, 32'hFFFF_FFF0);
        send_sample(1'b0, 32'h0000_0050);
        send_sample(1'b0, 32'h0000_0300);
        send_sample(1'b1, 32'h0000_0000);
        send_sample(1'b0, 32'hFFFF_FFFF);
        send_sample(1'b0, 32'h0000_0000);
    endtask

    task automatic test_threshold_extremes();
        logic [TIME_W-1:0] base;
        base = $urandom;
        program_registers('0, '0, '0, '0);
        send_sample(1'b1, base);
        send_sample(1'b1, base + 5);
        send_sample(1'b0, base + 10);
        send_sample(1'b1, base + 11);
        send_sample(1'b0, base + 11);
        program_registers('0, '0, '0, '1);
        send_sample(1'b1, base + 100);
        send_sample(1'b1, base + 100 + 65534);
        send_sample(1'b1, base + 100 + 65535);
        send_sample(1'b0, base + 100 + 65536);
        program_registers('0, '0, '1, '1);
        send_sample(1'b1, base + 200000);
        send_sample(1'b0, base + 200000);
        program_registers('1, '1, '1, '1);
        send_sample(1'b1, base + 300000);
        send_sample(1'b0, base + 300000 + 65534);
        send_sample(1'b1, base + 400000);
        send_sample(1'b0, base + 400000 + 65535);
        send_sample(1'b0, base + 400000 + 65535 + 65534);
        send_sample(1'b0, base + 400000 + 65535 + 65535);
    endtask

    task automatic test_unused_registers();
        program_registers(16'd30, 16'd250, 16'd800, 16'd2000);
        for (int idx = int'(CFG_FACTORY_RESET_TIME) + 1; idx < (1 << CFG_IDX_W); idx++) begin
            write_register(t_cfg_idx'(idx), CFG_DATA_W'($urandom));
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
        repeat (8) run_gesture();
    endtask

    task automatic test_output_backpressure();
        program_registers(16'd20, 16'd120, 16'd300, 16'd900);
        park_req = 1'b1;
        repeat (15) run_gesture();
        wait_results_drained();
        repeat (5) run_gesture();
        wait_results_drained();
    endtask

    task automatic test_random_gestures();
        int phase_end;
        while (items_sent < ITEM_TARGET - QUIET_ITEMS) begin
            program_registers(pick_setting(), pick_setting(), pick_setting(), pick_setting());
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) run_gesture();
        end
        wait_results_drained();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        program_registers(16'd10, 16'd200, 16'd500, 16'd1500);
        phase_end = items_sent + QUIET_ITEMS;
        while (items_sent < phase_end) run_gesture();
        wait_results_drained();
    endtask

    initial begin
        forever begin
            @(posedge clk);
            if (park_req) begin
                out_ready <= 1'b0;
                repeat (PARK_CYCLES) @(posedge clk);
                park_req = 1'b0;
                out_ready <= 1'b1;
            end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_reports.size() == 0) begin
                $error("result with nothing expected: %p", out_data);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                if (out_data.taps_done !== want.taps_done) begin
                    $error("taps_done: expected %0d, got %0d", want.taps_done, out_data.taps_done);
                    mismatches++;
                end
                if (out_data.long_press_event !== want.long_press_event) begin
                    $error("long_press_event: expected %0b, got %0b",
                           want.long_press_event, out_data.long_press_event);
                    mismatches++;
                end
                if (out_data.factory_reset_event !== want.factory_reset_event) begin
                    $error("factory_reset_event: expected %0b, got %0b",
                           want.factory_reset_event, out_data.factory_reset_event);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        reset_tracker();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_gestures();
        test_threshold_extremes();
        test_unused_registers();
        test_output_backpressure();
        test_random_gestures();
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
